### sv/three_anchor_trilateration_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-anchor trilateration block
// Implication checks on the block clock with reset disabled.
// ----------------------------------------------------------------------------
`ifndef THREE_ANCHOR_TRILATERATION_MACROS_SVH
`define THREE_ANCHOR_TRILATERATION_MACROS_SVH

// same-cycle implication
`define TAT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TAT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// Widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tat_pkg;

	localparam int OPA_W  = 37;             // multiplier operand A
	localparam int OPB_W  = 18;             // multiplier operand B
	localparam int PROD_W = OPA_W + OPB_W;  // product and accumulators
	localparam int DVS_W  = 37;             // divisor magnitude
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);

	// multiplier operand selection
	localparam logic [4:0] MUL_NONE = 5'd0;
	localparam logic [4:0] MUL_RS2  = 5'd1;
	localparam logic [4:0] MUL_RB2  = 5'd2;
	localparam logic [4:0] MUL_RC2  = 5'd3;
	localparam logic [4:0] MUL_SX2  = 5'd4;
	localparam logic [4:0] MUL_SY2  = 5'd5;
	localparam logic [4:0] MUL_BX2  = 5'd6;
	localparam logic [4:0] MUL_BY2  = 5'd7;
	localparam logic [4:0] MUL_CX2  = 5'd8;
	localparam logic [4:0] MUL_CY2  = 5'd9;
	localparam logic [4:0] MUL_EA   = 5'd10;
	localparam logic [4:0] MUL_BD   = 5'd11;
	localparam logic [4:0] MUL_CE   = 5'd12;
	localparam logic [4:0] MUL_FB   = 5'd13;
	localparam logic [4:0] MUL_AF   = 5'd14;
	localparam logic [4:0] MUL_CD   = 5'd15;

	// accumulator destinations
	localparam logic [2:0] ACC_NONE = 3'd0;
	localparam logic [2:0] ACC_C    = 3'd1;
	localparam logic [2:0] ACC_F    = 3'd2;
	localparam logic [2:0] ACC_DEN  = 3'd3;
	localparam logic [2:0] ACC_NX   = 3'd4;
	localparam logic [2:0] ACC_NY   = 3'd5;

	typedef struct packed {
		logic       load_own;
		logic       load_b;
		logic       load_c;
		logic       clr;
		logic [4:0] mul_sel;
		logic [2:0] acc_dst;
		logic       acc_sub;
		logic       div_start;
		logic       div_y;
		logic       wr_x;
		logic       wr_y;
		logic       wr_deg;
		logic       wr_out;
	} tat_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_done;
	} tat_status_t;

endpackage

### sv/tat_div.sv
// ----------------------------------------------------------------------------
// tat_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tat_div
	import tat_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [DVS_W-1:0]    divisor,
	output logic                done,
	output logic [PROD_W-1:0]   quotient
);

	logic [DVS_W-1:0]     rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/tat_datapath.sv
// ----------------------------------------------------------------------------
// tat_datapath
// Ranges, shared multiplier with accumulators, divider and result registers.
// ----------------------------------------------------------------------------
module tat_datapath
	import tat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tat_cmd_t           cmd,
	output tat_status_t        status,
	input  logic [15:0]        range_mm,
	input  logic signed [15:0] self_x,
	input  logic signed [15:0] self_y,
	input  logic signed [15:0] anchor_b_x,
	input  logic signed [15:0] anchor_b_y,
	input  logic signed [15:0] anchor_c_x,
	input  logic signed [15:0] anchor_c_y,
	output logic signed [15:0] x_mm,
	output logic signed [15:0] y_mm,
	output logic               degenerate
);

	logic [15:0]              own_q, rb_q, rc_q;
	logic signed [OPB_W-1:0]  a_q, b_q, d_q, e_q;
	logic signed [PROD_W-1:0] c_q, f_q, den_q, nx_q, ny_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [2:0]               dst_s1;
	logic                     sub_s1;
	logic signed [OPA_W-1:0]  op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic signed [PROD_W-1:0] addend;
	logic signed [PROD_W-1:0] num;
	logic [PROD_W-1:0]        num_mag;
	logic [DVS_W-1:0]         den_mag;
	logic                     neg_q;
	logic                     div_done;
	logic [PROD_W-1:0]        quo;
	logic signed [15:0]       sat;
	logic signed [15:0]       x_q, y_q;
	logic                     deg_q;
	logic signed [15:0]       x_out_q, y_out_q;
	logic                     deg_out_q;

	function automatic logic signed [OPA_W-1:0] ext_a(input logic signed [15:0] v);
		ext_a = OPA_W'(v);
	endfunction

	function automatic logic signed [OPB_W-1:0] ext_b(input logic signed [15:0] v);
		ext_b = OPB_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			rb_q  <= '0;
		end else begin
			if (cmd.load_own)
				own_q <= range_mm;
			if (cmd.load_b)
				rb_q <= range_mm;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_c)
			rc_q <= range_mm;
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			MUL_RS2: begin op_a = OPA_W'(own_q); op_b = OPB_W'(own_q); end
			MUL_RB2: begin op_a = OPA_W'(rb_q);  op_b = OPB_W'(rb_q);  end
			MUL_RC2: begin op_a = OPA_W'(rc_q);  op_b = OPB_W'(rc_q);  end
			MUL_SX2: begin op_a = ext_a(self_x);     op_b = ext_b(self_x);     end
			MUL_SY2: begin op_a = ext_a(self_y);     op_b = ext_b(self_y);     end
			MUL_BX2: begin op_a = ext_a(anchor_b_x); op_b = ext_b(anchor_b_x); end
			MUL_BY2: begin op_a = ext_a(anchor_b_y); op_b = ext_b(anchor_b_y); end
			MUL_CX2: begin op_a = ext_a(anchor_c_x); op_b = ext_b(anchor_c_x); end
			MUL_CY2: begin op_a = ext_a(anchor_c_y); op_b = ext_b(anchor_c_y); end
			MUL_EA:  begin op_a = OPA_W'(e_q); op_b = a_q; end
			MUL_BD:  begin op_a = OPA_W'(b_q); op_b = d_q; end
			MUL_CE:  begin op_a = c_q[OPA_W-1:0]; op_b = e_q; end
			MUL_FB:  begin op_a = f_q[OPA_W-1:0]; op_b = b_q; end
			MUL_AF:  begin op_a = f_q[OPA_W-1:0]; op_b = a_q; end
			MUL_CD:  begin op_a = c_q[OPA_W-1:0]; op_b = d_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign addend = sub_s1 ? -prod_s1 : prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		dst_s1  <= cmd.clr ? ACC_NONE : cmd.acc_dst;
		sub_s1  <= cmd.acc_sub;
		if (cmd.clr) begin
			a_q   <= OPB_W'(ext_b(anchor_b_x) - ext_b(self_x)) <<< 1;
			b_q   <= OPB_W'(ext_b(anchor_b_y) - ext_b(self_y)) <<< 1;
			d_q   <= OPB_W'(ext_b(anchor_c_x) - ext_b(anchor_b_x)) <<< 1;
			e_q   <= OPB_W'(ext_b(anchor_c_y) - ext_b(anchor_b_y)) <<< 1;
			c_q   <= '0;
			f_q   <= '0;
			den_q <= '0;
			nx_q  <= '0;
			ny_q  <= '0;
		end else begin
			unique case (dst_s1)
				ACC_C:   c_q   <= c_q + addend;
				ACC_F:   f_q   <= f_q + addend;
				ACC_DEN: den_q <= den_q + addend;
				ACC_NX:  nx_q  <= nx_q + addend;
				ACC_NY:  ny_q  <= ny_q + addend;
				default: ;
			endcase
		end
	end

	// magnitudes in, sign reapplied after: truncation toward zero
	assign num     = cmd.div_y ? ny_q : nx_q;
	assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign den_mag = den_q[PROD_W-1] ? DVS_W'(-den_q) : DVS_W'(den_q);

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			neg_q <= num[PROD_W-1] ^ den_q[PROD_W-1];
	end

	tat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag),
		.divisor  (den_mag),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (!neg_q)
			sat = (quo > PROD_W'(32767)) ? 16'sh7fff : $signed(quo[15:0]);
		else
			sat = (quo > PROD_W'(32768)) ? 16'sh8000 : $signed(16'(-quo[15:0]));
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_x)
			x_q <= sat;
		if (cmd.wr_y)
			y_q <= sat;
		if (cmd.wr_deg) begin
			x_q   <= '0;
			y_q   <= '0;
			deg_q <= 1'b1;
		end else if (cmd.wr_y) begin
			deg_q <= 1'b0;
		end
	end

	// hold the offered transaction while the next solve runs
	always_ff @(posedge clk) begin
		if (cmd.wr_out) begin
			x_out_q   <= x_q;
			y_out_q   <= y_q;
			deg_out_q <= deg_q;
		end
	end

	assign status.den_zero = (den_q == '0);
	assign status.div_done = div_done;
	assign x_mm       = x_out_q;
	assign y_mm       = y_out_q;
	assign degenerate = deg_out_q;

endmodule

### sv/tat_ctrl.sv
// ----------------------------------------------------------------------------
// tat_ctrl
// Item decode, solve sequencer and output handshake.
// ----------------------------------------------------------------------------
module tat_ctrl
	import tat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] sender_address,
	input  logic [15:0] anchor_b_addr,
	input  logic [15:0] anchor_c_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output tat_cmd_t    cmd,
	input  tat_status_t status
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_WAITX = 3'd3;
	localparam logic [2:0] ST_DIVY  = 3'd4;
	localparam logic [2:0] ST_WAITY = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;

	localparam int          STEPS  = 19;
	localparam logic [4:0]  LAST   = 5'(STEPS - 1);

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic       have_b_q;
	logic       out_valid_q;
	logic       accept;
	logic       is_b, is_c;
	logic       can_write;
	logic [4:0] mul_sel;
	logic [2:0] acc_dst;
	logic       acc_sub;

	// multiply-accumulate schedule; the product is registered and lands in its accumulator in the next cycle
	always_comb begin
		mul_sel = MUL_NONE;
		acc_dst = ACC_NONE;
		acc_sub = 1'b0;
		unique case (step_q)
			5'd0:  begin mul_sel = MUL_RS2; acc_dst = ACC_C;   end
			5'd1:  begin mul_sel = MUL_RB2; acc_dst = ACC_C;   acc_sub = 1'b1; end
			5'd2:  begin mul_sel = MUL_SX2; acc_dst = ACC_C;   acc_sub = 1'b1; end
			5'd3:  begin mul_sel = MUL_BX2; acc_dst = ACC_C;   end
			5'd4:  begin mul_sel = MUL_SY2; acc_dst = ACC_C;   acc_sub = 1'b1; end
			5'd5:  begin mul_sel = MUL_BY2; acc_dst = ACC_C;   end
			5'd6:  begin mul_sel = MUL_RB2; acc_dst = ACC_F;   end
			5'd7:  begin mul_sel = MUL_RC2; acc_dst = ACC_F;   acc_sub = 1'b1; end
			5'd8:  begin mul_sel = MUL_BX2; acc_dst = ACC_F;   acc_sub = 1'b1; end
			5'd9:  begin mul_sel = MUL_CX2; acc_dst = ACC_F;   end
			5'd10: begin mul_sel = MUL_BY2; acc_dst = ACC_F;   acc_sub = 1'b1; end
			5'd11: begin mul_sel = MUL_CY2; acc_dst = ACC_F;   end
			5'd12: begin mul_sel = MUL_EA;  acc_dst = ACC_DEN; end
			5'd13: begin mul_sel = MUL_BD;  acc_dst = ACC_DEN; acc_sub = 1'b1; end
			5'd14: begin mul_sel = MUL_CE;  acc_dst = ACC_NX;  end
			5'd15: begin mul_sel = MUL_FB;  acc_dst = ACC_NX;  acc_sub = 1'b1; end
			5'd16: begin mul_sel = MUL_AF;  acc_dst = ACC_NY;  end
			5'd17: begin mul_sel = MUL_CD;  acc_dst = ACC_NY;  acc_sub = 1'b1; end
			default: ;
		endcase
	end

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign is_b      = !have_b_q && (sender_address == anchor_b_addr);
	assign is_c      = have_b_q && (sender_address == anchor_c_addr);
	assign can_write = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = (state_q == ST_MUL) ? mul_sel : MUL_NONE;
		cmd.acc_dst   = (state_q == ST_MUL) ? acc_dst : ACC_NONE;
		cmd.acc_sub   = acc_sub;
		cmd.load_own  = accept && !func;
		cmd.load_b    = accept && func && is_b;
		cmd.load_c    = accept && func && !is_b && is_c;
		cmd.clr       = cmd.load_c;
		cmd.div_start = ((state_q == ST_CHECK) && !status.den_zero) ||
			((state_q == ST_DIVY));
		cmd.div_y     = (state_q == ST_DIVY);
		cmd.wr_x      = (state_q == ST_WAITX) && status.div_done;
		cmd.wr_y      = (state_q == ST_WAITY) && status.div_done;
		cmd.wr_deg    = (state_q == ST_CHECK) && status.den_zero;
		cmd.wr_out    = (state_q == ST_WRITE) && can_write;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			have_b_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func) begin
						have_b_q <= is_b;
						if (!is_b && is_c) begin
							step_q  <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= status.den_zero ? ST_WRITE : ST_WAITX;
				end
				ST_WAITX: begin
					if (status.div_done)
						state_q <= ST_DIVY;
				end
				ST_DIVY: state_q <= ST_WAITY;
				ST_WAITY: begin
					if (status.div_done)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					// hold until the previous result has left
					if (can_write)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### sv/three_anchor_trilateration.sv
// An own-range or report transaction that starts no solve keeps the input free. A solve
// runs from acceptance to out_valid through 19 multiply steps, a check state, two
// 55-step bit-serial divisions, a divider restart between them and a write state.
// Degenerate solves skip the divisions; a stalled result holds WRITE.
// Throughput: one transaction per cycle while no solve runs; a solve stalls the input.
// Reset clears own and B ranges, pending B mark and handshake; registers take defaults.
// ----------------------------------------------------------------------------
// three_anchor_trilateration
// Three-anchor 2D position solver with an APB register port.
// ----------------------------------------------------------------------------
`include "three_anchor_trilateration_macros.svh"

module three_anchor_trilateration
	import tat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [15:0]        sender_address,
	input  logic [15:0]        range_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] x_mm,
	output logic signed [15:0] y_mm,
	output logic               degenerate
);

	localparam logic [2:0] REG_SELF_X = 3'd0;
	localparam logic [2:0] REG_SELF_Y = 3'd1;
	localparam logic [2:0] REG_B_X    = 3'd2;
	localparam logic [2:0] REG_B_Y    = 3'd3;
	localparam logic [2:0] REG_C_X    = 3'd4;
	localparam logic [2:0] REG_C_Y    = 3'd5;
	localparam logic [2:0] REG_B_ADDR = 3'd6;
	localparam logic [2:0] REG_C_ADDR = 3'd7;

	logic signed [15:0] self_x_q, self_y_q, b_x_q, b_y_q, c_x_q, c_y_q;
	logic [15:0]        b_addr_q, c_addr_q;
	logic               wr_en;
	logic [2:0]         reg_idx;
	tat_cmd_t           cmd;
	tat_status_t        status;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_x_q <= 16'sd0;
			self_y_q <= 16'sd0;
			b_x_q    <= 16'sd3000;
			b_y_q    <= 16'sd0;
			c_x_q    <= 16'sd3000;
			c_y_q    <= 16'sd2500;
			b_addr_q <= 16'd2;
			c_addr_q <= 16'd3;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SELF_X: self_x_q <= pwdata[15:0];
				REG_SELF_Y: self_y_q <= pwdata[15:0];
				REG_B_X:    b_x_q    <= pwdata[15:0];
				REG_B_Y:    b_y_q    <= pwdata[15:0];
				REG_C_X:    c_x_q    <= pwdata[15:0];
				REG_C_Y:    c_y_q    <= pwdata[15:0];
				REG_B_ADDR: b_addr_q <= pwdata[15:0];
				REG_C_ADDR: c_addr_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SELF_X: prdata = 32'(self_x_q);
			REG_SELF_Y: prdata = 32'(self_y_q);
			REG_B_X:    prdata = 32'(b_x_q);
			REG_B_Y:    prdata = 32'(b_y_q);
			REG_C_X:    prdata = 32'(c_x_q);
			REG_C_Y:    prdata = 32'(c_y_q);
			REG_B_ADDR: prdata = {16'd0, b_addr_q};
			REG_C_ADDR: prdata = {16'd0, c_addr_q};
			default:    prdata = '0;
		endcase
	end

	tat_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.sender_address (sender_address),
		.anchor_b_addr  (b_addr_q),
		.anchor_c_addr  (c_addr_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.status         (status)
	);

	tat_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.range_mm   (range_mm),
		.self_x     (self_x_q),
		.self_y     (self_y_q),
		.anchor_b_x (b_x_q),
		.anchor_b_y (b_y_q),
		.anchor_c_x (c_x_q),
		.anchor_c_y (c_y_q),
		.x_mm       (x_mm),
		.y_mm       (y_mm),
		.degenerate (degenerate)
	);

	`TAT_ASSERT_IMP(a_deg_zero, out_valid && degenerate, x_mm == '0 && y_mm == '0, "deg nonzero")
	`TAT_ASSERT_IMP(a_rise_busy, $rose(out_valid), $past(in_stall), "result without a solve")
	`TAT_ASSERT_NXT(a_no_accept_busy, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule
